/* design/pf2rgb_pkg.sv */
// Shared types, format codes and fixed-point constants for the pixel
// format to RGB converter. No dependencies.
package pf2rgb_pkg;

   typedef enum logic [2:0] {
      FMT_BGRA = 3'd0,
      FMT_RGBA = 3'd1,
      FMT_BGR3 = 3'd2,
      FMT_NV12 = 3'd3,
      FMT_I420 = 3'd4,
      FMT_YUY2 = 3'd5
   } fmt_type;

   localparam int ACC_W = 28;

   localparam logic signed [ACC_W-1:0] Q16_Y    = 28'sd76309;
   localparam logic signed [ACC_W-1:0] Q16_RV   = 28'sd117489;
   localparam logic signed [ACC_W-1:0] Q16_GU   = 28'sd13975;
   localparam logic signed [ACC_W-1:0] Q16_GV   = 28'sd34925;
   localparam logic signed [ACC_W-1:0] Q16_BU   = 28'sd138438;
   localparam logic signed [ACC_W-1:0] Q16_HALF = 28'sd32768;

   localparam logic signed [8:0] LUMA_OFS   = 9'sd16;
   localparam logic signed [8:0] CHROMA_OFS = 9'sd128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // round half up, clamp to 0..255
   function automatic logic [7:0] sat_channel(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      logic [ACC_W-17:0]       t;
      sum = acc + Q16_HALF;
      t   = sum[ACC_W-1:16];
      if (acc < 0) begin
         return 8'd0;
      end else if (t > (ACC_W-16)'(255)) begin
         return 8'd255;
      end else begin
         return t[7:0];
      end
   endfunction

endpackage

/* design/pf2rgb_if.sv */
// Valid/ready channel interfaces for the pixel request and the RGB result.
// Depends on nothing.
interface pf2rgb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic       odd_column;

   modport source (output valid, func, byte0, byte1, byte2, byte3, odd_column,
                   input ready);
   modport sink   (input valid, func, byte0, byte1, byte2, byte3, odd_column,
                   output ready);
endinterface

interface pf2rgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       valid_res;

   modport source (output valid, red, green, blue, valid_res, input ready);
   modport sink   (input valid, red, green, blue, valid_res, output ready);
endinterface

/* design/pf2rgb_yuv.sv */
// BT.709 limited-range YCbCr to RGB matrix in Q16, rounded and saturated.
// Depends on pf2rgb_pkg.
module pf2rgb_yuv (
   input  logic [7:0]          luma,
   input  logic [7:0]          cb,
   input  logic [7:0]          cr,
   output pf2rgb_pkg::rgb_type rgb
);

   logic signed [8:0] y_d;
   logic signed [8:0] u_d;
   logic signed [8:0] v_d;
   logic signed [pf2rgb_pkg::ACC_W-1:0] yy;
   logic signed [pf2rgb_pkg::ACC_W-1:0] r_acc;
   logic signed [pf2rgb_pkg::ACC_W-1:0] g_acc;
   logic signed [pf2rgb_pkg::ACC_W-1:0] b_acc;

   assign y_d = signed'({1'b0, luma}) - pf2rgb_pkg::LUMA_OFS;
   assign u_d = signed'({1'b0, cb}) - pf2rgb_pkg::CHROMA_OFS;
   assign v_d = signed'({1'b0, cr}) - pf2rgb_pkg::CHROMA_OFS;

   assign yy    = pf2rgb_pkg::ACC_W'(y_d) * pf2rgb_pkg::Q16_Y;
   assign r_acc = yy + pf2rgb_pkg::ACC_W'(v_d) * pf2rgb_pkg::Q16_RV;
   assign g_acc = yy - pf2rgb_pkg::ACC_W'(u_d) * pf2rgb_pkg::Q16_GU
                     - pf2rgb_pkg::ACC_W'(v_d) * pf2rgb_pkg::Q16_GV;
   assign b_acc = yy + pf2rgb_pkg::ACC_W'(u_d) * pf2rgb_pkg::Q16_BU;

   assign rgb.red   = pf2rgb_pkg::sat_channel(r_acc);
   assign rgb.green = pf2rgb_pkg::sat_channel(g_acc);
   assign rgb.blue  = pf2rgb_pkg::sat_channel(b_acc);

endmodule

/* design/pixel_format_to_rgb_core.sv */
// Pixel format to RGB converter, top level.
// Depends on pf2rgb_pkg, pf2rgb_if and pf2rgb_yuv.
//
// Usage:
//   req_chan carries one pixel per item: format code, four raw bytes and the
//   column parity. rsp_chan returns one item per request: red, green, blue
//   and valid_res (0 with zero colors for an unsupported format code).
//   Packed RGB formats are reordered; NV12, I420 and YUY2 go through a
//   BT.709 limited-range matrix with rounding and saturation.
//
// Pipeline: input register, then result register, between request accept
//   and result valid.
// Throughput: one item per cycle while rsp_chan accepts results; the
//   constant-coefficient matrix between the input register and the result register sets the cycle time.
// Reset: synchronous, active high; both stages empty, req_chan.ready high.
// Stall: with rsp_chan.ready low the result holds, one more item is taken
//   into the input register, and then req_chan.ready drops.
module pixel_format_to_rgb_core (
   input  logic        clock,
   input  logic        reset,
   pf2rgb_req_if.sink  req_chan,
   pf2rgb_rsp_if.source rsp_chan
);

   logic                s1_valid_ff;
   logic [2:0]          func_ff;
   logic [7:0]          byte0_ff;
   logic [7:0]          byte1_ff;
   logic [7:0]          byte2_ff;
   logic [7:0]          byte3_ff;
   logic                odd_ff;

   logic                rsp_valid_ff;
   pf2rgb_pkg::rgb_type rgb_ff;
   pf2rgb_pkg::rgb_type rgb_in;
   logic                res_ok_ff;
   logic                res_ok_in;

   logic                out_free;
   logic                req_take;
   logic [7:0]          luma_sel;
   logic [7:0]          cr_sel;
   pf2rgb_pkg::rgb_type yuv_rgb;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff  <= req_chan.func;
         byte0_ff <= req_chan.byte0;
         byte1_ff <= req_chan.byte1;
         byte2_ff <= req_chan.byte2;
         byte3_ff <= req_chan.byte3;
         odd_ff   <= req_chan.odd_column;
      end
   end

   always_comb begin
      if (func_ff == pf2rgb_pkg::FMT_YUY2) begin
         luma_sel = odd_ff ? byte2_ff : byte0_ff;
         cr_sel   = byte3_ff;
      end else begin
         luma_sel = byte0_ff;
         cr_sel   = byte2_ff;
      end
   end

   pf2rgb_yuv u_yuv (
      .luma (luma_sel),
      .cb   (byte1_ff),
      .cr   (cr_sel),
      .rgb  (yuv_rgb)
   );

   always_comb begin
      res_ok_in = 1'b1;
      case (func_ff)
         pf2rgb_pkg::FMT_BGRA, pf2rgb_pkg::FMT_BGR3: begin
            rgb_in = '{red: byte2_ff, green: byte1_ff, blue: byte0_ff};
         end
         pf2rgb_pkg::FMT_RGBA: begin
            rgb_in = '{red: byte0_ff, green: byte1_ff, blue: byte2_ff};
         end
         pf2rgb_pkg::FMT_NV12, pf2rgb_pkg::FMT_I420, pf2rgb_pkg::FMT_YUY2: begin
            rgb_in = yuv_rgb;
         end
         default: begin
            rgb_in    = '0;
            res_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rgb_ff    <= rgb_in;
         res_ok_ff <= res_ok_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red       = rgb_ff.red;
   assign rsp_chan.green     = rgb_ff.green;
   assign rsp_chan.blue      = rgb_ff.blue;
   assign rsp_chan.valid_res = res_ok_ff;

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item lost from input register");

   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(func_ff) && $stable(byte0_ff))
      else $error("input register changed while stalled");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_free |=> rsp_valid_ff)
      else $error("item did not reach result register");

   a_bad_fmt_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_ok_ff |-> rgb_ff == '0)
      else $error("unsupported format gave nonzero color");

endmodule
